// ===== hw/rtl/tcqs_pkg.sv =====
`default_nettype none
package tcqs_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_WIDTH    = 16;

  localparam int QIDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W    = QIDX_W + 1;
  localparam int RAM_AW   = QIDX_W + 2;
  localparam int RAM_DEPTH = 3 << QIDX_W;

  localparam int RUN_W    = 4;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [RUN_W-1:0] RUN_MAX       = 4'd15;
  localparam logic [RUN_W-1:0] MAX_RUN_RESET = 4'd3;

  // register index (byte address / 4)
  localparam logic [CFG_ADDR_W-3:0] REG_MAX_RUN = '0;

  localparam logic [1:0] REQ_ENQUEUE = 2'd0;
  localparam logic [1:0] REQ_SERVE   = 2'd1;
  localparam logic [1:0] REQ_CLEAR   = 2'd2;

  localparam logic [1:0] CLASS_REGULAR = 2'd0;
  localparam logic [1:0] CLASS_HIGH    = 2'd1;
  localparam logic [1:0] CLASS_TOP     = 2'd2;
  // no queue behind this code; enqueues to it are ignored
  localparam logic [1:0] CLASS_NONE    = 2'd3;

  typedef logic [ID_WIDTH-1:0] id_t;

  // item between the accept cycle and the memory read data
  typedef struct packed {
    logic       grant;
    logic [1:0] cls;
    logic       dropped;
  } stage_t;

  typedef struct packed {
    logic       grant_valid;
    id_t        granted_id;
    logic [1:0] granted_class;
    logic       enqueue_dropped;
  } res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tcqs_in_if.sv =====
`default_nettype none
interface tcqs_in_if;
  import tcqs_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [1:0] class_code;
  id_t        request_id;

  modport source (output valid, output req_type, output class_code, output request_id,
                  input ready);
  modport sink   (input valid, input req_type, input class_code, input request_id,
                  output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tcqs_out_if.sv =====
`default_nettype none
interface tcqs_out_if;
  import tcqs_pkg::*;

  logic       valid;
  logic       ready;
  logic       grant_valid;
  id_t        granted_id;
  logic [1:0] granted_class;
  logic       enqueue_dropped;

  modport source (output valid, output grant_valid, output granted_id,
                  output granted_class, output enqueue_dropped, input ready);
  modport sink   (input valid, input grant_valid, input granted_id,
                  input granted_class, input enqueue_dropped, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tcqs_ram.sv =====
`default_nettype none
module tcqs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== hw/rtl/three_class_queue_scheduler_top.sv =====
`default_nettype none
// Three-class queue scheduler: regular, high and top FIFOs of request ids with
// strict priority bounded by a starvation limit on consecutive priority grants.
//
// in_if  : request words (req_type, class_code, request_id), valid/ready.
//          Enqueue files an id, serve pops one, clear resets the run counter.
// out_if : one result word per request word (grant_valid, granted_id,
//          granted_class, enqueue_dropped), valid/ready.
// cfg_*  : APB-style port, register 0 at byte address 0 is max_priority_run.
//
// Throughput is one word per cycle while the receiver keeps up. The grant
// decision and queue pointers update at accept, the id is read out of the
// shared id memory through its registered read port, and the output register
// then takes it.
// A stalled receiver backs up the output register, then the read stage, then
// in_if.ready drops; nothing is lost.
// Reset empties all queues, clears the run counter and sets max_priority_run to
// 3. The id memory is not cleared; only occupied entries are ever read.
module three_class_queue_scheduler_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  tcqs_in_if.sink                              in_if,
  tcqs_out_if.source                           out_if,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [tcqs_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [tcqs_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output      logic [tcqs_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output      logic                            cfg_pready
);
  import tcqs_pkg::*;

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);
  localparam logic [QIDX_W-1:0] IDX_LAST  = QIDX_W'(QUEUE_DEPTH - 1);
  localparam logic [SUM_W-1:0]  SUM_DEPTH = SUM_W'(QUEUE_DEPTH);

  logic [QIDX_W-1:0] head_r [3];
  logic [QIDX_W-1:0] head_nxt [3];
  logic [FILL_W-1:0] fill_r [3];
  logic [FILL_W-1:0] fill_nxt [3];
  logic [RUN_W-1:0]  run_r, run_nxt;
  logic [RUN_W-1:0]  max_run_r, max_run_nxt;

  stage_t st_r, st_nxt;
  logic   st_valid_r, st_valid_nxt;
  res_t   out_r, out_nxt;
  logic   out_valid_r, out_valid_nxt;

  logic       acc;
  logic       st_adv;
  logic [2:0] waiting;
  logic       any_prio;
  logic [1:0] gcls;
  logic       grant;
  logic       enq_ok;
  logic       enq_full;
  logic [QIDX_W-1:0] enq_head;
  logic [FILL_W-1:0] enq_fill;
  logic [QIDX_W-1:0] pop_head;
  logic [SUM_W-1:0]  tail_sum;
  logic [QIDX_W-1:0] tail_idx;
  logic       cfg_wr;
  logic       ram_we;
  logic       ram_re;
  logic [RAM_AW-1:0] ram_waddr, ram_raddr;
  id_t        ram_rdata;

  assign st_adv   = st_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !st_valid_r || st_adv;
  assign acc      = in_if.valid && in_if.ready;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      waiting[c] = (fill_r[c] != '0);
    end
  end

  assign any_prio = waiting[CLASS_TOP] || waiting[CLASS_HIGH];

  // grant choice: priority while under the run limit, else regular, else fallback
  always_comb begin
    grant = 1'b1;
    gcls  = CLASS_REGULAR;
    if ((run_r < max_run_r) && any_prio) begin
      gcls = waiting[CLASS_TOP] ? CLASS_TOP : CLASS_HIGH;
    end else if (waiting[CLASS_REGULAR]) begin
      gcls = CLASS_REGULAR;
    end else if (any_prio) begin
      gcls = waiting[CLASS_TOP] ? CLASS_TOP : CLASS_HIGH;
    end else begin
      grant = 1'b0;
    end
  end

  always_comb begin
    enq_head = '0;
    enq_fill = '0;
    pop_head = '0;
    for (int c = 0; c < 3; c++) begin
      if (in_if.class_code == 2'(c)) begin
        enq_head = head_r[c];
        enq_fill = fill_r[c];
      end
      if (gcls == 2'(c)) begin
        pop_head = head_r[c];
      end
    end
  end

  assign enq_full = (enq_fill == FILL_FULL);
  assign tail_sum = SUM_W'(enq_head) + SUM_W'(enq_fill);
  assign tail_idx = (tail_sum >= SUM_DEPTH) ? QIDX_W'(tail_sum - SUM_DEPTH)
                                            : QIDX_W'(tail_sum);
  assign enq_ok   = (in_if.class_code != CLASS_NONE) && !enq_full;

  assign ram_we    = acc && (in_if.req_type == REQ_ENQUEUE) && enq_ok;
  assign ram_waddr = {in_if.class_code, tail_idx};
  assign ram_re    = acc && (in_if.req_type == REQ_SERVE) && grant;
  assign ram_raddr = {gcls, pop_head};

  tcqs_ram #(
    .WIDTH (ID_WIDTH),
    .DEPTH (RAM_DEPTH)
  ) u_id_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_if.request_id),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      head_nxt[c] = head_r[c];
      fill_nxt[c] = fill_r[c];
    end
    run_nxt = run_r;
    st_nxt  = st_r;
    if (acc) begin
      st_nxt = '0;
      case (in_if.req_type)
        REQ_ENQUEUE: begin
          for (int c = 0; c < 3; c++) begin
            if ((in_if.class_code == 2'(c)) && !enq_full) begin
              fill_nxt[c] = fill_r[c] + 1'b1;
            end
          end
          st_nxt.dropped = (in_if.class_code != CLASS_NONE) && enq_full;
        end
        REQ_SERVE: begin
          if (grant) begin
            for (int c = 0; c < 3; c++) begin
              if (gcls == 2'(c)) begin
                head_nxt[c] = (head_r[c] == IDX_LAST) ? '0 : head_r[c] + 1'b1;
                fill_nxt[c] = fill_r[c] - 1'b1;
              end
            end
            if (gcls == CLASS_REGULAR) begin
              run_nxt = '0;
            end else if (run_r != RUN_MAX) begin
              run_nxt = run_r + 1'b1;
            end
            st_nxt.grant = 1'b1;
            st_nxt.cls   = gcls;
          end
        end
        REQ_CLEAR: begin
          run_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    st_valid_nxt = st_valid_r;
    if (acc) begin
      st_valid_nxt = 1'b1;
    end else if (st_adv) begin
      st_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (st_adv) begin
      out_nxt.grant_valid     = st_r.grant;
      out_nxt.granted_id      = st_r.grant ? ram_rdata : '0;
      out_nxt.granted_class   = st_r.cls;
      out_nxt.enqueue_dropped = st_r.dropped;
      out_valid_nxt           = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite &&
                  (cfg_paddr[CFG_ADDR_W-1:2] == REG_MAX_RUN);
  assign max_run_nxt = cfg_wr ? cfg_pwdata[RUN_W-1:0] : max_run_r;
  assign cfg_pready  = 1'b1;
  assign cfg_prdata  = (cfg_paddr[CFG_ADDR_W-1:2] == REG_MAX_RUN) ?
                       CFG_DATA_W'(max_run_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 3; c++) begin
        head_r[c] <= '0;
        fill_r[c] <= '0;
      end
      run_r       <= '0;
      max_run_r   <= MAX_RUN_RESET;
      st_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      for (int c = 0; c < 3; c++) begin
        head_r[c] <= head_nxt[c];
        fill_r[c] <= fill_nxt[c];
      end
      run_r       <= run_nxt;
      max_run_r   <= max_run_nxt;
      st_valid_r  <= st_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_r  <= st_nxt;
    out_r <= out_nxt;
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.grant_valid     = out_r.grant_valid;
  assign out_if.granted_id      = out_r.granted_id;
  assign out_if.granted_class   = out_r.granted_class;
  assign out_if.enqueue_dropped = out_r.enqueue_dropped;

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r[0] <= FILL_FULL) && (fill_r[1] <= FILL_FULL) && (fill_r[2] <= FILL_FULL))
    else $error("queue fill beyond depth");

  a_grant_xor_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.grant_valid && out_r.enqueue_dropped))
    else $error("word carries both grant and drop");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (st_valid_r && out_valid_r && !out_if.ready) |-> !in_if.ready)
    else $error("input taken while read stage blocked");

  a_regular_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_re && (gcls == CLASS_REGULAR)) |=> (run_r == '0))
    else $error("run counter not cleared on regular grant");

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none
module tb_top;
  import tcqs_pkg::*;

  localparam logic [1:0] REQ_NOP    = 2'd3;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int SETTLE_CYCLES   = 6;
  localparam int HOLD_CYCLES     = 80;
  localparam int HOLD_SPACING    = 450;
  localparam int WORDS_PER_PHASE = 205;
  localparam int NUM_PHASES      = 6;

  // run limits visited after the directed part, extremes included
  localparam logic [RUN_W-1:0] RUN_SETTINGS [NUM_PHASES] = '{4'd1, 4'd15, 4'd0, 4'd7,
                                                             4'd3, 4'd2};

  typedef struct packed {
    logic [1:0] req;
    logic [1:0] cls;
    id_t        id;
  } req_word_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  tcqs_in_if  req_ch ();
  tcqs_out_if res_ch ();

  three_class_queue_scheduler_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (req_ch),
    .out_if      (res_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #2 clk = ~clk;

  req_word_t   req_backlog[$];
  res_t        sched_results_due[$];

  // scheduler state as the block should hold it
  id_t              class_ids [3][$];
  logic [RUN_W-1:0] run_count;
  logic [RUN_W-1:0] run_limit;

  int unsigned mismatches   = 0;
  int unsigned words_in     = 0;
  int unsigned quiet_cycles = 0;
  logic        word_taken   = 1'b0;
  int unsigned burst_left   = 0;
  int unsigned gap_left     = 0;

  int unsigned rx_period    = 1;
  int unsigned rx_duty      = 0;
  int unsigned rx_left      = 0;
  int unsigned rx_tick      = 0;
  int unsigned hold_left    = 0;
  int unsigned next_hold_at = 300;

  function automatic res_t schedule_word(input req_word_t w);
    res_t       r;
    logic       hit;
    logic [1:0] pick;
    r    = '0;
    hit  = 1'b0;
    pick = CLASS_REGULAR;
    case (w.req)
      REQ_ENQUEUE: begin
        if (w.cls != CLASS_NONE) begin
          if (class_ids[w.cls].size() >= QUEUE_DEPTH) r.enqueue_dropped = 1'b1;
          else class_ids[w.cls].push_back(w.id);
        end
      end
      REQ_SERVE: begin
        if (run_count < run_limit) begin
          if (class_ids[CLASS_TOP].size() != 0) begin
            pick = CLASS_TOP;
            hit  = 1'b1;
          end else if (class_ids[CLASS_HIGH].size() != 0) begin
            pick = CLASS_HIGH;
            hit  = 1'b1;
          end
        end
        // run limit reached or nothing prioritised: regular first, then fall back
        if (!hit) begin
          if (class_ids[CLASS_REGULAR].size() != 0) begin
            pick = CLASS_REGULAR;
            hit  = 1'b1;
          end else if (class_ids[CLASS_TOP].size() != 0) begin
            pick = CLASS_TOP;
            hit  = 1'b1;
          end else if (class_ids[CLASS_HIGH].size() != 0) begin
            pick = CLASS_HIGH;
            hit  = 1'b1;
          end
        end
        if (hit) begin
          if (pick == CLASS_REGULAR) run_count = '0;
          else if (run_count != RUN_MAX) run_count = run_count + 1'b1;
          r.grant_valid   = 1'b1;
          r.granted_class = pick;
          r.granted_id    = class_ids[pick].pop_front();
        end
      end
      REQ_CLEAR: run_count = '0;
      default: ;
    endcase
    return r;
  endfunction

  function automatic req_word_t mk_word(input logic [1:0] req, input logic [1:0] cls,
                                        input id_t id);
    req_word_t w;
    w.req = req;
    w.cls = cls;
    w.id  = id;
    return w;
  endfunction

  function automatic req_word_t random_word(input int unsigned enq_pct,
                                            input int unsigned reg_pct);
    req_word_t   w;
    int unsigned roll;
    w.cls = 2'($urandom_range(0, 3));
    w.id  = id_t'($urandom);
    roll  = $urandom_range(0, 99);
    if (roll < 3) begin
      w.req = REQ_NOP;
    end else if (roll < 7) begin
      w.req = REQ_CLEAR;
    end else if ($urandom_range(0, 99) < enq_pct) begin
      w.req = REQ_ENQUEUE;
      roll  = $urandom_range(0, 99);
      if (roll < 3) w.cls = CLASS_NONE;
      else if (roll < reg_pct) w.cls = CLASS_REGULAR;
      else w.cls = $urandom_range(0, 1) ? CLASS_HIGH : CLASS_TOP;
    end else begin
      w.req = REQ_SERVE;
    end
    return w;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      if (mismatches < 40)
        $display("%0t: %s expected %h got %h", $time, what, want, got);
      mismatches++;
    end
  endtask

  task automatic drain_scheduler();
    while (req_backlog.size() != 0 || sched_results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_max_run(input logic [RUN_W-1:0] limit);
    cfg_paddr   = {REG_MAX_RUN, 2'b00};
    cfg_pwdata  = CFG_DATA_W'(limit);
    cfg_pwrite  = 1'b1;
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    run_limit = limit;
    @(negedge clk);
    cfg_pwrite  = 1'b0;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    check_field("max_priority_run readback", CFG_DATA_W'(limit), cfg_prdata);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // sender: accept at the rising edge, offer at the falling edge
  always @(posedge clk) begin
    word_taken = 1'b0;
    if (rst_n && req_ch.valid && req_ch.ready) begin
      sched_results_due.push_back(schedule_word(req_backlog.pop_front()));
      word_taken = 1'b1;
      words_in++;
    end
  end

  always @(negedge clk) begin
    // an offered word stays put until taken
    if (!(req_ch.valid && !word_taken)) begin
      if (gap_left != 0) begin
        req_ch.valid <= 1'b0;
        gap_left--;
      end else if (req_backlog.size() != 0) begin
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= req_backlog[0].req;
        req_ch.class_code <= req_backlog[0].cls;
        req_ch.request_id <= req_backlog[0].id;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: duty-cycle stalls, plus a long hold-off now and then
  always @(negedge clk) begin
    if (hold_left != 0) begin
      res_ch.ready <= 1'b0;
      hold_left--;
    end else if (words_in >= next_hold_at) begin
      res_ch.ready <= 1'b0;
      hold_left    = HOLD_CYCLES - 1;
      next_hold_at = next_hold_at + HOLD_SPACING;
    end else begin
      if (rx_left == 0) begin
        rx_period = $urandom_range(1, 8);
        rx_duty   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, rx_period - 1);
        rx_left   = $urandom_range(10, 80);
        rx_tick   = 0;
      end
      rx_left--;
      res_ch.ready <= (rx_tick % rx_period) >= rx_duty;
      rx_tick++;
    end
  end

  always @(posedge clk) begin
    res_t due;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (sched_results_due.size() == 0) begin
        if (mismatches < 40)
          $display("%0t: result word expected none got grant %0d id %h class %0d drop %0d",
                   $time, res_ch.grant_valid, res_ch.granted_id, res_ch.granted_class,
                   res_ch.enqueue_dropped);
        mismatches++;
      end else begin
        due = sched_results_due.pop_front();
        check_field("grant_valid", 32'(due.grant_valid), 32'(res_ch.grant_valid));
        check_field("granted_id", 32'(due.granted_id), 32'(res_ch.granted_id));
        check_field("granted_class", 32'(due.granted_class), 32'(res_ch.granted_class));
        check_field("enqueue_dropped", 32'(due.enqueue_dropped),
                    32'(res_ch.enqueue_dropped));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned counted;
    int unsigned seg_left;
    int unsigned enq_pct;
    int unsigned reg_pct;
    req_word_t   w;

    req_ch.valid      = 1'b0;
    req_ch.req_type   = REQ_ENQUEUE;
    req_ch.class_code = CLASS_REGULAR;
    req_ch.request_id = '0;
    res_ch.ready      = 1'b0;
    run_count         = '0;
    run_limit         = MAX_RUN_RESET;

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty serve, no-op and bad class, then a full top queue
    // starving a regular request until the run limit lets it through
    req_backlog.push_back(mk_word(REQ_SERVE, CLASS_NONE, 16'hffff));
    req_backlog.push_back(mk_word(REQ_NOP, CLASS_NONE, 16'hffff));
    req_backlog.push_back(mk_word(REQ_ENQUEUE, CLASS_NONE, 16'hffff));
    req_backlog.push_back(mk_word(REQ_ENQUEUE, CLASS_REGULAR, 16'h0000));
    req_backlog.push_back(mk_word(REQ_ENQUEUE, CLASS_HIGH, 16'hffff));
    req_backlog.push_back(mk_word(REQ_ENQUEUE, CLASS_TOP, 16'hffff));
    req_backlog.push_back(mk_word(REQ_ENQUEUE, CLASS_TOP, 16'h0000));
    for (int i = 2; i < QUEUE_DEPTH; i++)
      req_backlog.push_back(mk_word(REQ_ENQUEUE, CLASS_TOP, id_t'($urandom)));
    req_backlog.push_back(mk_word(REQ_ENQUEUE, CLASS_TOP, 16'h5aa5));
    repeat (4) req_backlog.push_back(mk_word(REQ_SERVE, CLASS_REGULAR, 16'h0000));
    req_backlog.push_back(mk_word(REQ_CLEAR, CLASS_TOP, 16'hffff));
    drain_scheduler();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_max_run(RUN_SETTINGS[p]);
      counted  = 0;
      seg_left = 0;
      while (counted < WORDS_PER_PHASE) begin
        // each segment draws its own enqueue share and regular-class share
        if (seg_left == 0) begin
          seg_left = $urandom_range(20, 60);
          enq_pct  = $urandom_range(25, 80);
          reg_pct  = $urandom_range(10, 60);
        end
        w = random_word(enq_pct, reg_pct);
        req_backlog.push_back(w);
        if (!(w.req == REQ_NOP || (w.req == REQ_ENQUEUE && w.cls == CLASS_NONE)))
          counted++;
        seg_left--;
      end
      drain_scheduler();
    end

    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
